// ===== rtl/core/icmpre_pkg.sv =====
`timescale 1ns / 1ps

package icmpre_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned ByteCntW = 16;
  localparam int unsigned WposW    = 3;

  localparam logic [ByteCntW-1:0] MAX_PACKET_BYTES = 16'hFFFF;
  localparam logic [ByteCntW-1:0] HDR_BYTES        = 16'd8;
  localparam logic [WordW-1:0]    MASK16           = 16'hFFFF;

  // header word slots, position saturates at WPOS_BODY
  localparam logic [WposW-1:0] WPOS_TC   = 3'd0;
  localparam logic [WposW-1:0] WPOS_CK   = 3'd1;
  localparam logic [WposW-1:0] WPOS_ID   = 3'd2;
  localparam logic [WposW-1:0] WPOS_SEQ  = 3'd3;
  localparam logic [WposW-1:0] WPOS_BODY = 3'd4;

  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
  localparam logic [7:0] TYPE_UNREACH    = 8'd3;
  localparam logic [7:0] TYPE_ECHO_REQ   = 8'd8;
  localparam logic [7:0] TYPE_TIME_EXC   = 8'd11;

  typedef enum logic [2:0] {
    VRD_SHORT     = 3'd0,
    VRD_BAD_CKSUM = 3'd1,
    VRD_ECHO_REQ  = 3'd2,
    VRD_ECHO_REP  = 3'd3,
    VRD_UNREACH   = 3'd4,
    VRD_TIME_EXC  = 3'd5,
    VRD_OTHER     = 3'd6
  } verdict_e;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             odd_byte;
    logic             last;
  } item_t;

  // message state including the current word
  typedef struct packed {
    logic [WordW-1:0]    type_code_word;
    logic [WordW-1:0]    received_checksum;
    logic [WordW-1:0]    echo_id;
    logic [WordW-1:0]    echo_seq;
    logic [WordW-1:0]    verify_sum;
    logic [WordW-1:0]    reply_sum;
    logic [ByteCntW-1:0] byte_count;
  } msg_t;

  // first member sits in the top bits, so verdict ends up at bit 0
  typedef struct packed {
    logic [15:0] payload_bytes;
    logic [15:0] reply_checksum;
    logic [15:0] sequence_res;
    logic [15:0] identifier;
    logic [7:0]  msg_code;
    logic [7:0]  msg_type;
    verdict_e    verdict;
  } result_t;

  localparam int unsigned ResW  = $bits(result_t);
  localparam int unsigned TdatW = ((ResW + 7) / 8) * 8;

  // ones-complement add with end-around carry; the result never exceeds 16 bits
  function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] s,
                                              input logic [WordW-1:0] w);
    logic [WordW:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[WordW-1:0] + {{(WordW-1){1'b0}}, t[WordW]};
  endfunction

endpackage

// ===== rtl/core/icmpre_acc.sv =====
`timescale 1ns / 1ps

module icmpre_acc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  icmpre_pkg::item_t  item_i,
  output icmpre_pkg::msg_t   msg_o
);
  import icmpre_pkg::*;

  msg_t             msg_q;
  msg_t             msg_d;
  logic [WposW-1:0] wpos_q;
  logic [WposW-1:0] wpos_d;
  logic [WordW-1:0] w;
  logic             odd;
  logic [ByteCntW:0] cnt_sum;

  always_comb begin
    odd = item_i.last & item_i.odd_byte;
    w   = odd ? {item_i.word[WordW-1:8], 8'h00} : item_i.word;

    msg_d = msg_q;
    unique case (wpos_q)
      WPOS_TC: begin
        msg_d.type_code_word = w;
        msg_d.verify_sum     = oc_add(msg_q.verify_sum, w);
      end
      WPOS_CK: begin
        msg_d.received_checksum = w;
      end
      WPOS_ID: begin
        msg_d.echo_id    = w;
        msg_d.verify_sum = oc_add(msg_q.verify_sum, w);
        msg_d.reply_sum  = oc_add(msg_q.reply_sum, w);
      end
      WPOS_SEQ: begin
        msg_d.echo_seq   = w;
        msg_d.verify_sum = oc_add(msg_q.verify_sum, w);
        msg_d.reply_sum  = oc_add(msg_q.reply_sum, w);
      end
      default: begin
        msg_d.verify_sum = oc_add(msg_q.verify_sum, w);
        msg_d.reply_sum  = oc_add(msg_q.reply_sum, w);
      end
    endcase

    cnt_sum = {1'b0, msg_q.byte_count} + (odd ? 17'd1 : 17'd2);
    if (cnt_sum > {1'b0, MAX_PACKET_BYTES}) begin
      msg_d.byte_count = MAX_PACKET_BYTES;
    end else begin
      msg_d.byte_count = cnt_sum[ByteCntW-1:0];
    end

    wpos_d = (wpos_q < WPOS_BODY) ? wpos_q + 3'd1 : wpos_q;
  end

  assign msg_o = msg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_q  <= '0;
      wpos_q <= WPOS_TC;
    end else if (en_i) begin
      if (item_i.last) begin
        msg_q  <= '0;
        wpos_q <= WPOS_TC;
      end else begin
        msg_q  <= msg_d;
        wpos_q <= wpos_d;
      end
    end
  end

endmodule

// ===== rtl/core/icmpre_vrd.sv =====
`timescale 1ns / 1ps

module icmpre_vrd (
  input  icmpre_pkg::msg_t    msg_i,
  output icmpre_pkg::result_t res_o
);
  import icmpre_pkg::*;

  logic [7:0]       tp;
  logic [WordW-1:0] vsum_n;

  always_comb begin
    tp     = msg_i.type_code_word[15:8];
    vsum_n = ~msg_i.verify_sum & MASK16;

    res_o                = '0;
    res_o.msg_type       = tp;
    res_o.msg_code       = msg_i.type_code_word[7:0];
    res_o.identifier     = msg_i.echo_id;
    res_o.sequence_res   = msg_i.echo_seq;

    priority if (msg_i.byte_count < HDR_BYTES) begin
      res_o.verdict = VRD_SHORT;
    end else begin
      res_o.payload_bytes = msg_i.byte_count - HDR_BYTES;
      // exact compare: 0x0000 and 0xFFFF are distinct here
      priority if (vsum_n != msg_i.received_checksum) begin
        res_o.verdict = VRD_BAD_CKSUM;
      end else if (tp == TYPE_ECHO_REQ) begin
        res_o.verdict        = VRD_ECHO_REQ;
        res_o.reply_checksum = ~msg_i.reply_sum & MASK16;
      end else if (tp == TYPE_ECHO_REPLY) begin
        res_o.verdict = VRD_ECHO_REP;
      end else if (tp == TYPE_UNREACH) begin
        res_o.verdict = VRD_UNREACH;
      end else if (tp == TYPE_TIME_EXC) begin
        res_o.verdict = VRD_TIME_EXC;
      end else begin
        res_o.verdict = VRD_OTHER;
      end
    end
  end

endmodule

// ===== rtl/core/icmp_receive_echo_responder_unit.sv =====
`timescale 1ns / 1ps

// ICMP receive checker with echo responder.
// Slave stream: one 16-bit message word per beat, network byte order, tlast on
// the final word; tuser marks a final word that carries only its high byte.
// Master stream: one beat per message, with verdict, type, code, identifier,
// sequence, reply checksum (echo requests only) and payload length.
// Words pass an input register, then the checksum/header update and the
// verdict logic, and land in an output register. The result of a message
// appears on the master side once its last word has left the input register.
// Throughput is one word per cycle, but a last word waits while the master side
// holds a result; a new message may start in the cycle after the last word of the previous one.
// Reset clears the running sums, byte count and header fields and drops any
// word or result in flight. If the master side stalls, the output register
// holds its beat; body words keep flowing, and the input register stops only
// once a last word waits behind the held result.
module icmp_receive_echo_responder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [15:0]                   s_axis_tdata_i,  // word
  input  logic                          s_axis_tuser_i,  // odd_byte
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // verdict[2:0], msg_type[10:3], msg_code[18:11], identifier[34:19],
  // sequence_res[50:35], reply_checksum[66:51], payload_bytes[82:67], zeros above
  output logic [icmpre_pkg::TdatW-1:0]  m_axis_tdata_o
);
  import icmpre_pkg::*;

  logic    in_vld_q;
  item_t   in_q;
  logic    out_vld_q;
  result_t out_q;
  logic    out_free;
  logic    advance;
  msg_t    msg;
  result_t res;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && (!in_q.last || out_free);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.word     <= s_axis_tdata_i;
      in_q.odd_byte <= s_axis_tuser_i;
      in_q.last     <= s_axis_tlast_i;
    end
  end

  icmpre_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_q),
    .msg_o  (msg)
  );

  icmpre_vrd u_vrd (
    .msg_i (msg),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance && in_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && in_q.last) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(TdatW-ResW){1'b0}}, out_q};

endmodule
